// ===== sv/tcrd_pkg.sv =====
// shared types and constants for the tdm channel remap and delay block
// no dependencies; imported by tcrd_convert and tdm_channel_remap_delay
package tcrd_pkg;

  localparam int unsigned MapPositions = 8;
  localparam int unsigned SlotW        = 3;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned WordW        = 32;
  localparam int unsigned ShiftW       = 6;
  localparam int unsigned LenFieldW    = 6;
  localparam int unsigned CfgW         = 48;
  localparam int unsigned CfgIdxW      = 3;

  localparam logic [SampleW-1:0] DescrambleMask = 16'h59DF;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHANNEL_COUNT     = 3'd0,
    CFG_MIC_COUNT         = 3'd1,
    CFG_CONTAINER_MODE    = 3'd2,
    CFG_DESCRAMBLE_ENABLE = 3'd3,
    CFG_MIC_SHIFT         = 3'd4,
    CFG_REF_SHIFT         = 3'd5,
    CFG_CHANNEL_MAP       = 3'd6,
    CFG_DELAY_LENGTHS     = 3'd7
  } cfg_index_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SWAP,
    ST_OUT
  } seq_state_e;

  // controls for the sample conversion unit
  typedef struct packed {
    logic              container_mode;
    logic              descramble_enable;
    logic [ShiftW-1:0] shift;
  } conv_ctrl_t;

endpackage

// ===== sv/tdm_channel_remap_delay.sv =====
// top level of the tdm channel remap and delay block
// depends on tcrd_pkg, tcrd_convert and tcrd_ram
//
// Takes interleaved capture words, one per beat, converts each to a 16-bit
// sample and stores it at its frame position. The word that closes a frame
// starts a sequencer that walks the output slots in order; for each slot it
// looks up the first mapped position and, if the slot has a nonzero delay,
// swaps the sample with the oldest entry of that slot's ring in the delay ram
// (read in ST_LOOK, then write in ST_SWAP). Each output beat is held until
// m_axis_tready_i. No input beat is taken while the sequencer runs. Delay
// lines read as zero until their ring has wrapped once after reset or after a
// delay length write, so no clearing pass is needed.
module tdm_channel_remap_delay
  import tcrd_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned MAX_DELAY    = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input beat
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [31:0]        s_axis_tdata_i,   // [31:0] raw_sample
  // output beat
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [23:0]        m_axis_tdata_o,   // [15:0] out_sample, [18:16] out_slot
  output logic               m_axis_tlast_o,   // last_of_frame
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned PosLimit = (MAX_CHANNELS < MapPositions) ? MAX_CHANNELS
                                                                   : MapPositions;
  localparam int unsigned LenCap   = (MAX_DELAY < 63) ? MAX_DELAY : 63;
  localparam int unsigned PtrW     = $clog2(LenCap);
  localparam int unsigned CmpW     = (PtrW > LenFieldW) ? PtrW + 1 : LenFieldW + 1;
  localparam int unsigned RamDepth = MapPositions << PtrW;
  localparam int unsigned RamAddrW = SlotW + PtrW;

  function automatic logic [SlotW-1:0] slot_of(logic [23:0] map, logic [SlotW-1:0] pos);
    int unsigned base;
    base = 32'(pos) * 3;
    return map[base +: SlotW];
  endfunction

  // configuration registers
  logic [3:0]        chan_cnt_q, mic_cnt_q;
  logic              cont_q, desc_q;
  logic [ShiftW-1:0] mic_sh_q, ref_sh_q;
  logic [23:0]       map_q;
  logic [CfgW-1:0]   dly_q;

  // sequencer and datapath state
  seq_state_e        state_q, state_d;
  logic [SlotW-1:0]  pos_q, pos_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [SampleW-1:0] fb_q [MapPositions];
  logic [PtrW-1:0]   ptr_q [MapPositions];
  logic [MapPositions-1:0] wrap_q;
  logic [SampleW-1:0] out_sample_q;
  logic              out_last_q;

  // combinational signals
  logic [3:0]         nch;
  logic [SlotW-1:0]   pos_eff;
  logic               in_last;
  logic               mic_sel;
  conv_ctrl_t         conv_ctrl;
  logic [SampleW-1:0] conv_sample;
  logic [MapPositions-1:0] hit;
  logic [SampleW-1:0] slot_val;
  logic [LenFieldW-1:0] len_field, len_eff;
  logic [PtrW-1:0]    p_eff;
  logic [CmpW-1:0]    p_next;
  logic               p_wrap;
  logic [SampleW-1:0] ram_rdata, delayed;
  logic               fb_we, out_load, ram_we, ptr_upd;
  logic [SampleW-1:0] out_val;

  // effective channel count and frame position
  always_comb begin
    if (chan_cnt_q == 4'd0) begin
      nch = 4'd1;
    end else if (chan_cnt_q > 4'(PosLimit)) begin
      nch = 4'(PosLimit);
    end else begin
      nch = chan_cnt_q;
    end
    if ({1'b0, pos_q} >= 4'(PosLimit)) begin
      pos_eff = SlotW'(PosLimit - 1);
    end else begin
      pos_eff = pos_q;
    end
    in_last = (({1'b0, pos_eff} + 4'd1) >= nch);
    mic_sel = ({1'b0, slot_of(map_q, pos_eff)} < mic_cnt_q);
  end

  // conversion unit controls
  assign conv_ctrl.container_mode    = cont_q;
  assign conv_ctrl.descramble_enable = desc_q;
  assign conv_ctrl.shift             = mic_sel ? mic_sh_q : ref_sh_q;

  tcrd_convert u_convert (
    .word_i   (s_axis_tdata_i),
    .ctrl_i   (conv_ctrl),
    .sample_o (conv_sample)
  );

  // first position mapped to the current slot, zero when unmapped
  always_comb begin
    for (int i = 0; i < MapPositions; i++) begin
      hit[i] = (4'(i) < nch) && (slot_of(map_q, SlotW'(i)) == slot_q);
    end
    slot_val = '0;
    for (int i = MapPositions - 1; i >= 0; i--) begin
      if (hit[i]) begin
        slot_val = fb_q[i];
      end
    end
  end

  // delay length and ring pointer of the current slot
  always_comb begin
    int unsigned lbase;
    lbase     = 32'(slot_q) * LenFieldW;
    len_field = dly_q[lbase +: LenFieldW];
    len_eff   = (len_field > LenFieldW'(LenCap)) ? LenFieldW'(LenCap) : len_field;
    if (CmpW'(ptr_q[slot_q]) >= CmpW'(len_eff)) begin
      p_eff = '0;
    end else begin
      p_eff = ptr_q[slot_q];
    end
    p_next  = CmpW'(p_eff) + CmpW'(1);
    p_wrap  = (p_next >= CmpW'(len_eff));
    delayed = wrap_q[slot_q] ? ram_rdata : '0;
  end

  tcrd_ram #(
    .WIDTH (SampleW),
    .DEPTH (RamDepth)
  ) u_delay_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (RamAddrW'({slot_q, p_eff})),
    .wr_data_i (slot_val),
    .rd_addr_i (RamAddrW'({slot_q, p_eff})),
    .rd_data_o (ram_rdata)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and sequencer outputs
  always_comb begin
    state_d         = state_q;
    pos_d           = pos_q;
    slot_d          = slot_q;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    fb_we           = 1'b0;
    out_load        = 1'b0;
    out_val         = slot_val;
    ram_we          = 1'b0;
    ptr_upd         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          fb_we = 1'b1;
          if (in_last) begin
            pos_d   = '0;
            slot_d  = '0;
            state_d = ST_LOOK;
          end else begin
            pos_d = SlotW'(pos_eff + SlotW'(1));
          end
        end
      end
      ST_LOOK: begin
        if (len_eff != '0) begin
          state_d = ST_SWAP;
        end else begin
          out_load = 1'b1;
          state_d  = ST_OUT;
        end
      end
      ST_SWAP: begin
        ram_we   = 1'b1;
        ptr_upd  = 1'b1;
        out_load = 1'b1;
        out_val  = delayed;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          if (out_last_q) begin
            state_d = ST_IDLE;
          end else begin
            slot_d  = slot_q + SlotW'(1);
            state_d = ST_LOOK;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      slot_q <= '0;
    end else begin
      pos_q  <= pos_d;
      slot_q <= slot_d;
    end
  end

  // configuration registers; a delay length write restarts all rings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= 4'd8;
      mic_cnt_q  <= 4'd8;
      cont_q     <= 1'b0;
      desc_q     <= 1'b0;
      mic_sh_q   <= 6'd16;
      ref_sh_q   <= 6'd16;
      map_q      <= 24'hFAC688;
      dly_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_CHANNEL_COUNT:     chan_cnt_q <= cfg_data_i[3:0];
        CFG_MIC_COUNT:         mic_cnt_q  <= cfg_data_i[3:0];
        CFG_CONTAINER_MODE:    cont_q     <= cfg_data_i[0];
        CFG_DESCRAMBLE_ENABLE: desc_q     <= cfg_data_i[0];
        CFG_MIC_SHIFT:         mic_sh_q   <= cfg_data_i[ShiftW-1:0];
        CFG_REF_SHIFT:         ref_sh_q   <= cfg_data_i[ShiftW-1:0];
        CFG_CHANNEL_MAP:       map_q      <= cfg_data_i[23:0];
        CFG_DELAY_LENGTHS:     dly_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ring pointers and wrapped flags per slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MapPositions; i++) begin
        ptr_q[i] <= '0;
      end
      wrap_q <= '0;
    end else if (cfg_we_i && (cfg_index_e'(cfg_index_i) == CFG_DELAY_LENGTHS)) begin
      for (int i = 0; i < MapPositions; i++) begin
        ptr_q[i] <= '0;
      end
      wrap_q <= '0;
    end else if (ptr_upd) begin
      if (p_wrap) begin
        ptr_q[slot_q]  <= '0;
        wrap_q[slot_q] <= 1'b1;
      end else begin
        ptr_q[slot_q] <= PtrW'(p_next);
      end
    end
  end

  // frame buffer and output payload
  always_ff @(posedge clk_i) begin
    if (fb_we) begin
      fb_q[pos_eff] <= conv_sample;
    end
    if (out_load) begin
      out_sample_q <= out_val;
      out_last_q   <= (({1'b0, slot_q} + 4'd1) == nch);
    end
  end

  assign m_axis_tdata_o = {5'b0, slot_q, out_sample_q};
  assign m_axis_tlast_o = out_last_q;

endmodule

// ===== sv/tcrd_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
module tcrd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ===== sv/tcrd_convert.sv =====
// capture word to 16-bit sample conversion: arithmetic shift, descramble or low half passed through
// depends on tcrd_pkg
module tcrd_convert
  import tcrd_pkg::*;
(
  input  logic [WordW-1:0]   word_i,
  input  conv_ctrl_t         ctrl_i,
  output logic [SampleW-1:0] sample_o
);

  logic [4:0]              sh_amt;
  logic signed [WordW-1:0] shifted;
  logic [SampleW-1:0]      low_half;

  // shift amounts of 32 and beyond act as 31
  always_comb begin
    sh_amt   = (ctrl_i.shift > 6'd31) ? 5'd31 : ctrl_i.shift[4:0];
    shifted  = $signed(word_i) >>> sh_amt;
    low_half = word_i[SampleW-1:0];
    if (ctrl_i.container_mode) begin
      sample_o = shifted[SampleW-1:0];
    end else if (ctrl_i.descramble_enable && (low_half != '0)) begin
      sample_o = low_half ^ DescrambleMask;
    end else begin
      sample_o = low_half;
    end
  end

endmodule
